### rtl/scp_pkg.sv
// Shared types and constants for the segment closest-points pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package scp_pkg;

    localparam int COORD_W    = 32;
    localparam int COORD_FRAC = 16;
    localparam int PARAM_FRAC = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DOT_W      = PROD_W + 2;
    localparam int MOP_W      = 70;
    localparam int WIDE_W     = 2 * MOP_W;
    localparam int PP_CHUNK   = 14;
    localparam int PP_NUM     = MOP_W / PP_CHUNK;
    localparam int DIST_W     = 64;
    localparam int DIST_SHIFT = 2 * COORD_FRAC - 24;

    // squared-length threshold, 1e-6 in Q.32
    localparam logic [DOT_W-1:0] EPS_RAW = DOT_W'((64'd1 << (2 * COORD_FRAC)) / 64'd1000000);
    localparam logic [PARAM_FRAC:0] PARAM_ONE = (PARAM_FRAC + 1)'(1) << PARAM_FRAC;

    // edges from input transfer to result register
    localparam int LATENCY = 56;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [DOT_W-1:0]   dot_t;
    typedef logic signed [MOP_W-1:0]   mop_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;
    typedef logic [PARAM_FRAC:0]       param_t;

endpackage

### rtl/scp_mul.sv
// Five-stage signed multiplier, 70 x 70 -> 140 bits, sign-magnitude with 14-bit partials.
// Depends on scp_pkg.
`timescale 1ns / 1ps
module scp_mul (
    input  logic           clk,
    input  scp_pkg::mop_t  op_a,
    input  scp_pkg::mop_t  op_b,
    output scp_pkg::wide_t prod
);
    import scp_pkg::*;

    logic                            neg_reg [0:3];
    logic [MOP_W-1:0]                am_reg;
    logic [MOP_W-1:0]                bm_reg;
    logic [MOP_W+PP_CHUNK-1:0]       pp_reg [0:PP_NUM-1];
    logic [WIDE_W-1:0]               s01_reg;
    logic [WIDE_W-1:0]               s23_reg;
    logic [WIDE_W-1:0]               s4_reg;
    logic [WIDE_W-1:0]               sum_reg;
    logic [WIDE_W-1:0]               prod_reg;

    always_ff @(posedge clk)
    begin
        neg_reg[0] <= op_a[MOP_W-1] ^ op_b[MOP_W-1];
        am_reg     <= op_a[MOP_W-1] ? MOP_W'(-op_a) : MOP_W'(op_a);
        bm_reg     <= op_b[MOP_W-1] ? MOP_W'(-op_b) : MOP_W'(op_b);
        for (int j = 0; j < PP_NUM; j++)
        begin
            pp_reg[j] <= (MOP_W + PP_CHUNK)'(am_reg) *
                         (MOP_W + PP_CHUNK)'(bm_reg[j*PP_CHUNK +: PP_CHUNK]);
        end
        s01_reg  <= WIDE_W'(pp_reg[0]) + (WIDE_W'(pp_reg[1]) << PP_CHUNK);
        s23_reg  <= (WIDE_W'(pp_reg[2]) << (2 * PP_CHUNK)) +
                    (WIDE_W'(pp_reg[3]) << (3 * PP_CHUNK));
        s4_reg   <= WIDE_W'(pp_reg[4]) << (4 * PP_CHUNK);
        sum_reg  <= s01_reg + s23_reg + s4_reg;
        prod_reg <= neg_reg[3] ? (~sum_reg + WIDE_W'(1)) : sum_reg;
        for (int k = 1; k < 4; k++)
        begin
            neg_reg[k] <= neg_reg[k-1];
        end
    end

    assign prod = wide_t'(prod_reg);

endmodule

### rtl/scp_div.sv
// Clamped fraction num/den in Q1.16: one classify stage, then one restoring step per stage.
// Depends on scp_pkg. Takes one new operand pair per cycle.
`timescale 1ns / 1ps
module scp_div (
    input  logic            clk,
    input  scp_pkg::wide_t  num,
    input  scp_pkg::wide_t  den,
    output scp_pkg::param_t quo
);
    import scp_pkg::*;

    logic [WIDE_W-1:0]     rem_reg  [0:PARAM_FRAC];
    logic [WIDE_W-1:0]     den_reg  [0:PARAM_FRAC];
    logic [PARAM_FRAC-1:0] q_reg    [0:PARAM_FRAC];
    logic                  zero_reg [0:PARAM_FRAC];
    logic                  one_reg  [0:PARAM_FRAC];
    logic [WIDE_W:0]       shl_next [1:PARAM_FRAC];
    logic [WIDE_W:0]       sub_next [1:PARAM_FRAC];
    logic                  bit_next [1:PARAM_FRAC];

    always_comb
    begin
        for (int k = 1; k <= PARAM_FRAC; k++)
        begin
            shl_next[k] = {rem_reg[k-1], 1'b0};
            sub_next[k] = shl_next[k] - {1'b0, den_reg[k-1]};
            bit_next[k] = shl_next[k] >= {1'b0, den_reg[k-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg[0] <= (den <= 0) || (num <= 0);
        one_reg[0]  <= num >= den;
        rem_reg[0]  <= num;
        den_reg[0]  <= den;
        q_reg[0]    <= '0;
        for (int k = 1; k <= PARAM_FRAC; k++)
        begin
            rem_reg[k]  <= bit_next[k] ? sub_next[k][WIDE_W-1:0] : shl_next[k][WIDE_W-1:0];
            q_reg[k]    <= {q_reg[k-1][PARAM_FRAC-2:0], bit_next[k]};
            den_reg[k]  <= den_reg[k-1];
            zero_reg[k] <= zero_reg[k-1];
            one_reg[k]  <= one_reg[k-1];
        end
    end

    assign quo = zero_reg[PARAM_FRAC] ? '0 :
                 one_reg[PARAM_FRAC]  ? PARAM_ONE : {1'b0, q_reg[PARAM_FRAC]};

endmodule

### rtl/segment_closest_points.sv
// Closest points between two 3D segments, fully pipelined.
// Depends on scp_pkg, scp_mul and scp_div.
`timescale 1ns / 1ps
// Usage:
//   A pair of segments is transferred when start is high and busy is low.
//   busy stays low: the pipeline takes a new pair on every clock.
//   Coordinates are signed Q16.16. Each result is shown for one cycle with
//   done high: the two nearest points, s and t in Q1.16 (0..65536) and the
//   squared distance in Q40.24, saturated to all ones.
//   Throughput is one pair per cycle. The path is set by the chain of wide
//   multiplies (5 stages), the s divider (17 stages), the t divider (17
//   stages) and the final point and distance stages.
//   Results leave in input order. The receiver cannot stall, so nothing
//   holds the pipeline. Reset clears all valid bits; items in flight are
//   dropped and no done pulse follows until new pairs are transferred.
module segment_closest_points (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  scp_pkg::coord_t seg_a_start_x,
    input  scp_pkg::coord_t seg_a_start_y,
    input  scp_pkg::coord_t seg_a_start_z,
    input  scp_pkg::coord_t seg_a_end_x,
    input  scp_pkg::coord_t seg_a_end_y,
    input  scp_pkg::coord_t seg_a_end_z,
    input  scp_pkg::coord_t seg_b_start_x,
    input  scp_pkg::coord_t seg_b_start_y,
    input  scp_pkg::coord_t seg_b_start_z,
    input  scp_pkg::coord_t seg_b_end_x,
    input  scp_pkg::coord_t seg_b_end_y,
    input  scp_pkg::coord_t seg_b_end_z,
    output logic            done,
    output scp_pkg::coord_t near_a_x,
    output scp_pkg::coord_t near_a_y,
    output scp_pkg::coord_t near_a_z,
    output scp_pkg::coord_t near_b_x,
    output scp_pkg::coord_t near_b_y,
    output scp_pkg::coord_t near_b_z,
    output scp_pkg::param_t param_a,
    output scp_pkg::param_t param_b,
    output logic [scp_pkg::DIST_W-1:0] dist_squared
);
    import scp_pkg::*;

    localparam int CX_LEN = 42;
    localparam int QA_LEN = 25;
    localparam int TC_LEN = 17;
    localparam int OD_LEN = 8;
    localparam int BS_W   = DOT_W + PARAM_FRAC + 2;
    localparam int DS_W   = DIFF_W + PARAM_FRAC + 2;
    localparam int PT_W   = DS_W + 1;
    localparam int NP_W   = PT_W - PARAM_FRAC;
    localparam int DD_W   = NP_W + 1;
    localparam int SQ_W   = 2 * DD_W + 2;

    typedef struct packed {
        logic                          adeg;
        logic                          edeg;
        dot_t                          b;
        dot_t                          e;
        dot_t                          f;
        logic [2:0][COORD_W-1:0]       p1;
        logic [2:0][COORD_W-1:0]       p2;
        logic [2:0][DIFF_W-1:0]        d1;
        logic [2:0][DIFF_W-1:0]        d2;
    } ctx_t;

    typedef struct packed {
        param_t s_lo;
        param_t s_hi;
        param_t t_only;
    } qa_t;

    typedef struct packed {
        param_t s_gen;
        logic   tneg;
        logic   tgt;
    } tc_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] na;
        logic [2:0][COORD_W-1:0] nb;
        param_t                  s;
        param_t                  t;
    } od_t;

    logic [LATENCY:0] vld_reg;

    coord_t p1_reg [3];
    coord_t q1_reg [3];
    coord_t p2_reg [3];
    coord_t q2_reg [3];
    coord_t in_p1  [3];
    coord_t in_q1  [3];
    coord_t in_p2  [3];
    coord_t in_q2  [3];

    diff_t  d1_1_reg [3];
    diff_t  d2_1_reg [3];
    diff_t  r_1_reg  [3];
    coord_t p1_1_reg [3];
    coord_t p2_1_reg [3];

    prod_t  aa_reg [3];
    prod_t  ee_reg [3];
    prod_t  ff_reg [3];
    prod_t  cc_reg [3];
    prod_t  bb_reg [3];
    coord_t p1_2_reg [3];
    coord_t p2_2_reg [3];
    diff_t  d1_2_reg [3];
    diff_t  d2_2_reg [3];

    dot_t   a_reg;
    dot_t   e_reg;
    dot_t   f_reg;
    dot_t   c_reg;
    dot_t   b_reg;
    coord_t p1_3_reg [3];
    coord_t p2_3_reg [3];
    diff_t  d1_3_reg [3];
    diff_t  d2_3_reg [3];

    ctx_t   cx_reg [CX_LEN];
    qa_t    qa_reg [QA_LEN];
    tc_t    tc_reg [TC_LEN];
    od_t    od_reg [OD_LEN];

    wide_t  ae_prod;
    wide_t  bb_prod;
    wide_t  bf_prod;
    wide_t  ce_prod;
    wide_t  den9_reg;
    wide_t  snum9_reg;

    param_t q_s_lo;
    param_t q_s_hi;
    param_t q_t_only;
    param_t q_s_gen;
    param_t q_t;

    logic signed [BS_W-1:0] bs27_reg;
    param_t                 sg27_reg;
    wide_t                  tnum28_reg;
    wide_t                  tden28_reg;
    param_t                 sg28_reg;

    param_t s_sel;
    param_t t_sel;
    param_t s46_reg;
    param_t t46_reg;
    coord_t p1_46_reg [3];
    coord_t p2_46_reg [3];
    diff_t  d1_46_reg [3];
    diff_t  d2_46_reg [3];

    logic signed [DS_W-1:0] ds47_reg [3];
    logic signed [DS_W-1:0] dt47_reg [3];
    coord_t p1_47_reg [3];
    coord_t p2_47_reg [3];
    param_t s47_reg;
    param_t t47_reg;

    logic signed [PT_W-1:0] pa_sum [3];
    logic signed [PT_W-1:0] pb_sum [3];
    logic signed [NP_W-1:0] c1_48_reg [3];
    logic signed [NP_W-1:0] c2_48_reg [3];
    param_t s48_reg;
    param_t t48_reg;

    logic signed [DD_W-1:0] dd49_reg [3];
    wide_t                  sq_prod  [3];
    logic [SQ_W-1:0]        sum55_reg;
    logic [DIST_W-1:0]      dist_reg;

    assign busy = 1'b0;

    assign in_p1 = '{seg_a_start_x, seg_a_start_y, seg_a_start_z};
    assign in_q1 = '{seg_a_end_x, seg_a_end_y, seg_a_end_z};
    assign in_p2 = '{seg_b_start_x, seg_b_start_y, seg_b_start_z};
    assign in_q2 = '{seg_b_end_x, seg_b_end_y, seg_b_end_z};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LATENCY-1:0], start & ~busy};
        end
    end

    // front end: differences, component products, dot products
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            p1_reg[k] <= in_p1[k];
            q1_reg[k] <= in_q1[k];
            p2_reg[k] <= in_p2[k];
            q2_reg[k] <= in_q2[k];

            d1_1_reg[k] <= diff_t'(q1_reg[k]) - diff_t'(p1_reg[k]);
            d2_1_reg[k] <= diff_t'(q2_reg[k]) - diff_t'(p2_reg[k]);
            r_1_reg[k]  <= diff_t'(p1_reg[k]) - diff_t'(p2_reg[k]);
            p1_1_reg[k] <= p1_reg[k];
            p2_1_reg[k] <= p2_reg[k];

            aa_reg[k]   <= prod_t'(d1_1_reg[k]) * prod_t'(d1_1_reg[k]);
            ee_reg[k]   <= prod_t'(d2_1_reg[k]) * prod_t'(d2_1_reg[k]);
            ff_reg[k]   <= prod_t'(d2_1_reg[k]) * prod_t'(r_1_reg[k]);
            cc_reg[k]   <= prod_t'(d1_1_reg[k]) * prod_t'(r_1_reg[k]);
            bb_reg[k]   <= prod_t'(d1_1_reg[k]) * prod_t'(d2_1_reg[k]);
            p1_2_reg[k] <= p1_1_reg[k];
            p2_2_reg[k] <= p2_1_reg[k];
            d1_2_reg[k] <= d1_1_reg[k];
            d2_2_reg[k] <= d2_1_reg[k];

            p1_3_reg[k] <= p1_2_reg[k];
            p2_3_reg[k] <= p2_2_reg[k];
            d1_3_reg[k] <= d1_2_reg[k];
            d2_3_reg[k] <= d2_2_reg[k];
        end
        a_reg <= dot_t'(aa_reg[0]) + dot_t'(aa_reg[1]) + dot_t'(aa_reg[2]);
        e_reg <= dot_t'(ee_reg[0]) + dot_t'(ee_reg[1]) + dot_t'(ee_reg[2]);
        f_reg <= dot_t'(ff_reg[0]) + dot_t'(ff_reg[1]) + dot_t'(ff_reg[2]);
        c_reg <= dot_t'(cc_reg[0]) + dot_t'(cc_reg[1]) + dot_t'(cc_reg[2]);
        b_reg <= dot_t'(bb_reg[0]) + dot_t'(bb_reg[1]) + dot_t'(bb_reg[2]);
    end

    // context line carrying operands to the case select
    always_ff @(posedge clk)
    begin
        cx_reg[0].adeg <= a_reg <= $signed(EPS_RAW);
        cx_reg[0].edeg <= e_reg <= $signed(EPS_RAW);
        cx_reg[0].b    <= b_reg;
        cx_reg[0].e    <= e_reg;
        cx_reg[0].f    <= f_reg;
        for (int k = 0; k < 3; k++)
        begin
            cx_reg[0].p1[k] <= p1_3_reg[k];
            cx_reg[0].p2[k] <= p2_3_reg[k];
            cx_reg[0].d1[k] <= d1_3_reg[k];
            cx_reg[0].d2[k] <= d2_3_reg[k];
        end
        for (int i = 1; i < CX_LEN; i++)
        begin
            cx_reg[i] <= cx_reg[i-1];
        end
    end

    scp_mul u_mul_ae (.clk(clk), .op_a(mop_t'(a_reg)), .op_b(mop_t'(e_reg)), .prod(ae_prod));
    scp_mul u_mul_bb (.clk(clk), .op_a(mop_t'(b_reg)), .op_b(mop_t'(b_reg)), .prod(bb_prod));
    scp_mul u_mul_bf (.clk(clk), .op_a(mop_t'(b_reg)), .op_b(mop_t'(f_reg)), .prod(bf_prod));
    scp_mul u_mul_ce (.clk(clk), .op_a(mop_t'(c_reg)), .op_b(mop_t'(e_reg)), .prod(ce_prod));

    // fallback quotients, independent of s
    scp_div u_div_lo (.clk(clk), .num(-wide_t'(c_reg)), .den(wide_t'(a_reg)), .quo(q_s_lo));
    scp_div u_div_hi (.clk(clk), .num(wide_t'(b_reg) - wide_t'(c_reg)),
                      .den(wide_t'(a_reg)), .quo(q_s_hi));
    scp_div u_div_t0 (.clk(clk), .num(wide_t'(f_reg)), .den(wide_t'(e_reg)), .quo(q_t_only));

    always_ff @(posedge clk)
    begin
        den9_reg  <= ae_prod - bb_prod;
        snum9_reg <= bf_prod - ce_prod;
    end

    // a zero denominator lands in the divider's non-positive case, giving s = 0
    scp_div u_div_s (.clk(clk), .num(snum9_reg), .den(den9_reg), .quo(q_s_gen));

    always_ff @(posedge clk)
    begin
        bs27_reg   <= BS_W'(cx_reg[22].b) * $signed({1'b0, q_s_gen});
        sg27_reg   <= q_s_gen;
        tnum28_reg <= wide_t'(bs27_reg) + (wide_t'(cx_reg[23].f) <<< PARAM_FRAC);
        tden28_reg <= wide_t'(cx_reg[23].e) <<< PARAM_FRAC;
        sg28_reg   <= sg27_reg;
    end

    scp_div u_div_t (.clk(clk), .num(tnum28_reg), .den(tden28_reg), .quo(q_t));

    always_ff @(posedge clk)
    begin
        qa_reg[0].s_lo   <= q_s_lo;
        qa_reg[0].s_hi   <= q_s_hi;
        qa_reg[0].t_only <= q_t_only;
        for (int i = 1; i < QA_LEN; i++)
        begin
            qa_reg[i] <= qa_reg[i-1];
        end
        tc_reg[0].s_gen <= sg28_reg;
        tc_reg[0].tneg  <= tnum28_reg < 0;
        tc_reg[0].tgt   <= tnum28_reg > tden28_reg;
        for (int i = 1; i < TC_LEN; i++)
        begin
            tc_reg[i] <= tc_reg[i-1];
        end
    end

    always_comb
    begin
        priority if (cx_reg[CX_LEN-1].adeg && cx_reg[CX_LEN-1].edeg)
        begin
            s_sel = '0;
            t_sel = '0;
        end
        else if (cx_reg[CX_LEN-1].adeg)
        begin
            s_sel = '0;
            t_sel = qa_reg[QA_LEN-1].t_only;
        end
        else if (cx_reg[CX_LEN-1].edeg)
        begin
            s_sel = qa_reg[QA_LEN-1].s_lo;
            t_sel = '0;
        end
        else if (tc_reg[TC_LEN-1].tneg)
        begin
            s_sel = qa_reg[QA_LEN-1].s_lo;
            t_sel = '0;
        end
        else if (tc_reg[TC_LEN-1].tgt)
        begin
            s_sel = qa_reg[QA_LEN-1].s_hi;
            t_sel = PARAM_ONE;
        end
        else
        begin
            s_sel = tc_reg[TC_LEN-1].s_gen;
            t_sel = q_t;
        end
    end

    // back end: points from s and t, then squared distance
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pa_sum[k] = (PT_W'(p1_47_reg[k]) <<< PARAM_FRAC) + PT_W'(ds47_reg[k]);
            pb_sum[k] = (PT_W'(p2_47_reg[k]) <<< PARAM_FRAC) + PT_W'(dt47_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        s46_reg <= s_sel;
        t46_reg <= t_sel;
        s47_reg <= s46_reg;
        t47_reg <= t46_reg;
        s48_reg <= s47_reg;
        t48_reg <= t47_reg;
        for (int k = 0; k < 3; k++)
        begin
            p1_46_reg[k] <= coord_t'(cx_reg[CX_LEN-1].p1[k]);
            p2_46_reg[k] <= coord_t'(cx_reg[CX_LEN-1].p2[k]);
            d1_46_reg[k] <= diff_t'(cx_reg[CX_LEN-1].d1[k]);
            d2_46_reg[k] <= diff_t'(cx_reg[CX_LEN-1].d2[k]);

            ds47_reg[k]  <= DS_W'(d1_46_reg[k]) * $signed({1'b0, s46_reg});
            dt47_reg[k]  <= DS_W'(d2_46_reg[k]) * $signed({1'b0, t46_reg});
            p1_47_reg[k] <= p1_46_reg[k];
            p2_47_reg[k] <= p2_46_reg[k];

            c1_48_reg[k] <= pa_sum[k][PT_W-1:PARAM_FRAC];
            c2_48_reg[k] <= pb_sum[k][PT_W-1:PARAM_FRAC];

            dd49_reg[k]  <= DD_W'(c1_48_reg[k]) - DD_W'(c2_48_reg[k]);
            od_reg[0].na[k] <= c1_48_reg[k][COORD_W-1:0];
            od_reg[0].nb[k] <= c2_48_reg[k][COORD_W-1:0];
        end
        od_reg[0].s <= s48_reg;
        od_reg[0].t <= t48_reg;
        for (int i = 1; i < OD_LEN; i++)
        begin
            od_reg[i] <= od_reg[i-1];
        end
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_sq
            scp_mul u_mul_sq (
                .clk  (clk),
                .op_a (mop_t'(dd49_reg[g])),
                .op_b (mop_t'(dd49_reg[g])),
                .prod (sq_prod[g])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        sum55_reg <= SQ_W'(sq_prod[0]) + SQ_W'(sq_prod[1]) + SQ_W'(sq_prod[2]);
        if (sum55_reg[SQ_W-1:DIST_W+DIST_SHIFT] != '0)
        begin
            dist_reg <= '1;
        end
        else
        begin
            dist_reg <= sum55_reg[DIST_W+DIST_SHIFT-1:DIST_SHIFT];
        end
    end

    assign done         = vld_reg[LATENCY];
    assign near_a_x     = coord_t'(od_reg[OD_LEN-1].na[0]);
    assign near_a_y     = coord_t'(od_reg[OD_LEN-1].na[1]);
    assign near_a_z     = coord_t'(od_reg[OD_LEN-1].na[2]);
    assign near_b_x     = coord_t'(od_reg[OD_LEN-1].nb[0]);
    assign near_b_y     = coord_t'(od_reg[OD_LEN-1].nb[1]);
    assign near_b_z     = coord_t'(od_reg[OD_LEN-1].nb[2]);
    assign param_a      = od_reg[OD_LEN-1].s;
    assign param_b      = od_reg[OD_LEN-1].t;
    assign dist_squared = dist_reg;

endmodule

### rtl/scp_chk.sv
// Port-level checks for segment_closest_points, attached with a bind.
// Depends on scp_pkg.
`timescale 1ns / 1ps
module scp_chk (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input scp_pkg::coord_t seg_a_start_x,
    input scp_pkg::coord_t seg_a_start_y,
    input scp_pkg::coord_t seg_a_start_z,
    input scp_pkg::coord_t seg_b_start_x,
    input scp_pkg::coord_t seg_b_start_y,
    input scp_pkg::coord_t seg_b_start_z,
    input logic            done,
    input scp_pkg::coord_t near_a_x,
    input scp_pkg::coord_t near_a_y,
    input scp_pkg::coord_t near_a_z,
    input scp_pkg::coord_t near_b_x,
    input scp_pkg::coord_t near_b_y,
    input scp_pkg::coord_t near_b_z,
    input scp_pkg::param_t param_a,
    input scp_pkg::param_t param_b
);
    import scp_pkg::*;

    localparam int LAG = LATENCY + 1;

    a_done_has_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAG))
        else $error("result without a matching input transfer");

    a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (param_a <= PARAM_ONE) && (param_b <= PARAM_ONE))
        else $error("segment parameter out of range");

    a_s_zero_is_start: assert property (@(posedge clk) disable iff (!rst_n)
        (done && param_a == '0) |-> (near_a_x == $past(seg_a_start_x, LAG)) &&
            (near_a_y == $past(seg_a_start_y, LAG)) && (near_a_z == $past(seg_a_start_z, LAG)))
        else $error("s is zero but point on first segment is not its start");

    a_t_zero_is_start: assert property (@(posedge clk) disable iff (!rst_n)
        (done && param_b == '0) |-> (near_b_x == $past(seg_b_start_x, LAG)) &&
            (near_b_y == $past(seg_b_start_y, LAG)) && (near_b_z == $past(seg_b_start_z, LAG)))
        else $error("t is zero but point on second segment is not its start");

endmodule

bind segment_closest_points scp_chk u_scp_chk (.*);
